// ----- rtl/dds_pkg.sv -----
// Shared types, constants and register map for the differential-drive speed ramp.
package dds_pkg;

    // Field widths
    localparam int unsigned VEL_W      = 16;
    localparam int unsigned CODE_W     = 16;
    localparam int unsigned CFG_W      = 15;
    localparam int unsigned GAIN_W     = 24;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned CFG_IDX_W  = 3;

    // Wheel speed is v * 2^VS_SHIFT, motor code is gain * wheel / 2^CODE_SHIFT
    localparam int unsigned VS_SHIFT   = 8;
    localparam int unsigned CODE_SHIFT = 24;

    localparam int unsigned HALF_BASE_Q_DEF = 256;

    // Request queue between front and back end
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TOL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_GAIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_GAIN  = 3'd7;

    // Configuration reset values
    localparam logic [CFG_W-1:0]  RST_ACCEL_STEP  = 15'd10;
    localparam logic [CFG_W-1:0]  RST_ACCEL_LIMIT = 15'd100;
    localparam logic [CFG_W-1:0]  RST_DECEL_STEP  = 15'd10;
    localparam logic [CFG_W-1:0]  RST_DECEL_LIMIT = 15'd100;
    localparam logic [CFG_W-1:0]  RST_SPEED_TOL   = 15'd10;
    localparam logic [CFG_W-1:0]  RST_SPEED_LIMIT = 15'd2048;
    localparam logic [GAIN_W-1:0] RST_LEFT_GAIN   = 24'd65536;
    localparam logic [GAIN_W-1:0] RST_RIGHT_GAIN  = 24'd65536;

    // Drive mode codes on the input channel
    typedef enum logic [1:0] {
        MODE_STOP    = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_CMD     = 2'd2,
        MODE_IDLE    = 2'd3
    } t_mode;

    // Work classes handed from front to back end
    typedef enum logic [1:0] {
        OP_RAMP    = 2'd0,
        OP_PASS    = 2'd1,
        OP_DISABLE = 2'd2
    } t_op;

    // Result kinds
    localparam logic KIND_WHEEL   = 1'b0;
    localparam logic KIND_DISABLE = 1'b1;

    typedef struct packed {
        t_op                      op;
        logic signed [VEL_W-1:0]  target_velocity;
        logic signed [VEL_W-1:0]  target_omega;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- rtl/diff_drive_speed_ramp.sv -----
// Top level of the differential-drive speed ramp: front end, request queue and back end.
//
// Each accepted tick request is classified by the front end in the cycle it arrives: idle
// ticks are dropped there and give no result, the rest enter a two-entry queue. The back
// end takes one request at a time and produces one result for it. A motor-disable request
// goes straight to the output step, a pass-through command runs the clamp, mix, multiply,
// code and output steps, and a ramped command or stop runs the acceleration, velocity and
// snap steps first; the output step waits while the output is stalled. The sequencer
// updates acceleration and velocity in separate steps and builds each wheel product from
// a low 25 x 18 and a high 25 x 10 partial multiply on a shared cycle counter. The front
// end keeps taking requests while the queue has room, even while a result is waiting.
module diff_drive_speed_ramp #(
    parameter int unsigned HALF_BASE_Q = dds_pkg::HALF_BASE_Q_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [dds_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [dds_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_drive_mode,
    input  logic                                  i_use_profile,
    input  logic signed [dds_pkg::VEL_W-1:0]      i_target_velocity,
    input  logic signed [dds_pkg::VEL_W-1:0]      i_target_omega,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_result_kind,
    output logic signed [dds_pkg::CODE_W-1:0]     o_left_speed_code,
    output logic signed [dds_pkg::CODE_W-1:0]     o_right_speed_code
);
    import dds_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_req    w_push_req;
    t_req    w_head;
    t_q_stat w_q_stat;

    dds_front u_front (
        .i_in_valid        (i_in_valid),
        .i_drive_mode      (i_drive_mode),
        .i_use_profile     (i_use_profile),
        .i_target_velocity (i_target_velocity),
        .i_target_omega    (i_target_omega),
        .i_q_stat          (w_q_stat),
        .o_in_stall        (o_in_stall),
        .o_push            (w_push),
        .o_push_req        (w_push_req)
    );

    dds_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_req (w_push_req),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_stat     (w_q_stat)
    );

    dds_back #(
        .HALF_BASE_Q (HALF_BASE_Q)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_q_stat           (w_q_stat),
        .i_head             (w_head),
        .o_pop              (w_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_result_kind      (o_result_kind),
        .o_left_speed_code  (o_left_speed_code),
        .o_right_speed_code (o_right_speed_code)
    );

    // The queue is never written when full nor read when empty.
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("request pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("request popped from an empty queue");

    // Idle ticks are accepted but never queued.
    a_idle_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_drive_mode == MODE_IDLE)) |-> !w_push)
        else $error("idle tick entered the request queue");

    // A motor-disable result always carries zero wheel codes.
    a_disable_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind == KIND_DISABLE))
            |-> (o_left_speed_code == '0) && (o_right_speed_code == '0))
        else $error("disable result with non-zero wheel codes");

endmodule

// ----- rtl/dds_front.sv -----
// Front end: takes tick requests, drops idle ones and classifies the rest for the back end.
module dds_front (
    input  logic                             i_in_valid,
    input  logic [1:0]                       i_drive_mode,
    input  logic                             i_use_profile,
    input  logic signed [dds_pkg::VEL_W-1:0] i_target_velocity,
    input  logic signed [dds_pkg::VEL_W-1:0] i_target_omega,
    input  dds_pkg::t_q_stat                 i_q_stat,
    output logic                             o_in_stall,
    output logic                             o_push,
    output dds_pkg::t_req                    o_push_req
);
    import dds_pkg::*;

    logic take;

    assign o_in_stall = i_q_stat.full;
    assign take       = i_in_valid && !i_q_stat.full;

    always_comb begin
        o_push                     = 1'b0;
        o_push_req.op              = OP_RAMP;
        o_push_req.target_velocity = i_target_velocity;
        o_push_req.target_omega    = i_target_omega;
        case (i_drive_mode)
            MODE_STOP: begin
                // Stop ramps towards standstill with no turn, whatever was commanded.
                o_push                     = take;
                o_push_req.target_velocity = '0;
                o_push_req.target_omega    = '0;
            end
            MODE_RELEASE: begin
                o_push        = take;
                o_push_req.op = OP_DISABLE;
            end
            MODE_CMD: begin
                o_push        = take;
                o_push_req.op = i_use_profile ? OP_RAMP : OP_PASS;
            end
            default: begin
                // Idle ticks are absorbed here and never produce a result.
                o_push = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/dds_queue.sv -----
// Short request queue that decouples the front end from the back end.
module dds_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dds_pkg::t_req    i_push_req,
    input  logic             i_pop,
    output dds_pkg::t_req    o_head,
    output dds_pkg::t_q_stat o_stat
);
    import dds_pkg::*;

    t_req            r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]   r_count, n_count;

    function automatic logic [Q_AW-1:0] f_next(input logic [Q_AW-1:0] p);
        logic [Q_AW-1:0] res;
        if (p == Q_AW'(Q_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + 1'b1;
        end
        return res;
    endfunction

    assign o_head       = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = i_push ? f_next(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? f_next(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_req;
        end
    end

endmodule

// ----- rtl/dds_back.sv -----
// Back end: ramp state, speed clamp, wheel mixing, gain multiply and the output register.
module dds_back #(
    parameter int unsigned HALF_BASE_Q = dds_pkg::HALF_BASE_Q_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [dds_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [dds_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  dds_pkg::t_q_stat                      i_q_stat,
    input  dds_pkg::t_req                         i_head,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_result_kind,
    output logic signed [dds_pkg::CODE_W-1:0]     o_left_speed_code,
    output logic signed [dds_pkg::CODE_W-1:0]     o_right_speed_code
);
    import dds_pkg::*;

    localparam int unsigned HB_W    = $clog2(HALF_BASE_Q + 1);
    localparam int unsigned TURN_W  = HB_W + 17;
    localparam int unsigned VS_W    = VEL_W + VS_SHIFT;
    localparam int unsigned WHEEL_W = ((TURN_W > VS_W) ? TURN_W : VS_W) + 1;
    localparam int unsigned LO_W    = 17;
    localparam int unsigned HI_W    = WHEEL_W - LO_W;
    localparam int unsigned LO_PW   = GAIN_W + LO_W + 2;
    localparam int unsigned HI_PW   = GAIN_W + 1 + HI_W;
    localparam int unsigned PROD_W  = (LO_PW > HI_PW) ? LO_PW : HI_PW;
    localparam int unsigned ACC_W   = WHEEL_W + GAIN_W + 1;
    localparam int unsigned Q_W     = ACC_W - CODE_SHIFT;

    localparam logic signed [HB_W:0]    HALF_BASE_S = (HB_W + 1)'(HALF_BASE_Q);
    localparam logic signed [Q_W-1:0]   Q_MAX       = Q_W'(32'sd32767);
    localparam logic signed [Q_W-1:0]   Q_MIN       = Q_W'(-32'sd32768);
    localparam logic signed [VEL_W:0]   V17_MAX     = 17'sd32767;
    localparam logic signed [VEL_W:0]   V17_MIN     = -17'sd32768;
    localparam logic signed [CODE_W-1:0] CODE_MAX   = 16'sh7FFF;
    localparam logic signed [CODE_W-1:0] CODE_MIN   = 16'sh8000;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_ACC   = 9'b000000010,
        ST_VEL   = 9'b000000100,
        ST_SNAP  = 9'b000001000,
        ST_CLAMP = 9'b000010000,
        ST_MIX   = 9'b000100000,
        ST_MUL   = 9'b001000000,
        ST_CODE  = 9'b010000000,
        ST_SAT   = 9'b100000000
    } t_bstate;

    t_bstate r_state, n_state;

    logic [CFG_W-1:0]  r_accel_step, n_accel_step;
    logic [CFG_W-1:0]  r_accel_limit, n_accel_limit;
    logic [CFG_W-1:0]  r_decel_step, n_decel_step;
    logic [CFG_W-1:0]  r_decel_limit, n_decel_limit;
    logic [CFG_W-1:0]  r_speed_tol, n_speed_tol;
    logic [CFG_W-1:0]  r_speed_limit, n_speed_limit;
    logic [GAIN_W-1:0] r_left_gain, n_left_gain;
    logic [GAIN_W-1:0] r_right_gain, n_right_gain;

    logic signed [VEL_W-1:0] r_accel, n_accel;
    logic signed [VEL_W-1:0] r_vel, n_vel;

    t_req                      r_req, n_req;
    logic                      r_far, n_far;
    logic                      r_up, n_up;
    logic signed [VEL_W-1:0]   r_v, n_v;
    logic signed [TURN_W-1:0]  r_turn, n_turn;
    logic signed [WHEEL_W-1:0] r_wheel [2];
    logic signed [WHEEL_W-1:0] n_wheel [2];
    logic [1:0]                r_cnt, n_cnt;
    logic signed [PROD_W-1:0]  r_prod [2];
    logic signed [PROD_W-1:0]  n_prod [2];
    logic signed [ACC_W-1:0]   r_acc [2];
    logic signed [ACC_W-1:0]   n_acc [2];
    logic signed [Q_W-1:0]     r_q [2];
    logic signed [Q_W-1:0]     n_q [2];

    logic                     r_out_valid, n_out_valid;
    logic                     r_out_kind, n_out_kind;
    logic signed [CODE_W-1:0] r_out_left, n_out_left;
    logic signed [CODE_W-1:0] r_out_right, n_out_right;

    // Datapath helpers
    logic signed [VEL_W:0]     head_diff, snap_diff, clamp_abs_s;
    logic [VEL_W:0]            head_abs, snap_abs, clamp_abs;
    logic signed [VEL_W:0]     acc_step_s, acc_lim_s, dec_step_s, dec_lim_neg;
    logic signed [VEL_W:0]     acc_up, acc_dn, vel_sum, step17, tol_s, snap_tol;
    logic signed [VEL_W-1:0]   acc_new, vel_sat, v_sel, v_clamped;
    logic signed [TURN_W-1:0]  turn_c;
    logic signed [WHEEL_W-1:0] vs_c, turn_ext;
    logic [GAIN_W-1:0]         gain_sel [2];
    logic signed [LO_PW-1:0]   lo_prod [2];
    logic signed [HI_PW-1:0]   hi_prod [2];
    logic signed [Q_W-1:0]     q_c [2];
    logic signed [CODE_W-1:0]  right_sat, left_sat, left_code;
    logic                      out_free;

    function automatic logic signed [CODE_W-1:0] f_sat_q(input logic signed [Q_W-1:0] x);
        logic signed [CODE_W-1:0] res;
        if (x > Q_MAX) begin
            res = CODE_MAX;
        end else if (x < Q_MIN) begin
            res = CODE_MIN;
        end else begin
            res = x[CODE_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [VEL_W:0] f_abs17(input logic signed [VEL_W:0] x);
        logic [VEL_W:0] res;
        res = (x < 0) ? 17'(-x) : 17'(x);
        return res;
    endfunction

    // Ramp decision for the request at the queue head, against the current velocity
    assign head_diff = 17'(i_head.target_velocity) - 17'(r_vel);
    assign head_abs  = f_abs17(head_diff);

    assign acc_step_s  = {2'b00, r_accel_step};
    assign acc_lim_s   = {2'b00, r_accel_limit};
    assign dec_step_s  = {2'b00, r_decel_step};
    assign dec_lim_neg = -$signed({2'b00, r_decel_limit});
    assign acc_up      = 17'(r_accel) + acc_step_s;
    assign acc_dn      = 17'(r_accel) - dec_step_s;

    always_comb begin
        if (r_up) begin
            acc_new = (acc_up < acc_lim_s) ? acc_up[VEL_W-1:0] : acc_lim_s[VEL_W-1:0];
        end else begin
            acc_new = (acc_dn > dec_lim_neg) ? acc_dn[VEL_W-1:0] : dec_lim_neg[VEL_W-1:0];
        end
    end

    assign vel_sum = 17'(r_vel) + 17'(r_accel);
    always_comb begin
        if (vel_sum > V17_MAX) begin
            vel_sat = CODE_MAX;
        end else if (vel_sum < V17_MIN) begin
            vel_sat = CODE_MIN;
        end else begin
            vel_sat = vel_sum[VEL_W-1:0];
        end
    end

    // The snap band widens to the step just taken when that step is larger.
    assign step17    = r_far ? 17'(r_accel) : '0;
    assign tol_s     = {2'b00, r_speed_tol};
    assign snap_tol  = (step17 > tol_s) ? step17 : tol_s;
    assign snap_diff = 17'(r_req.target_velocity) - 17'(r_vel);
    assign snap_abs  = f_abs17(snap_diff);

    assign v_sel       = (r_req.op == OP_RAMP) ? r_vel : r_req.target_velocity;
    assign clamp_abs_s = 17'(v_sel);
    assign clamp_abs   = f_abs17(clamp_abs_s);
    always_comb begin
        if (clamp_abs > {2'b00, r_speed_limit}) begin
            v_clamped = (v_sel > 0) ? $signed({1'b0, r_speed_limit})
                                    : $signed(16'(16'd0 - {1'b0, r_speed_limit}));
        end else begin
            v_clamped = v_sel;
        end
    end

    assign turn_c   = HALF_BASE_S * r_req.target_omega;
    assign vs_c     = WHEEL_W'($signed({r_v, {VS_SHIFT{1'b0}}}));
    assign turn_ext = WHEEL_W'(r_turn);

    assign gain_sel[0] = r_left_gain;
    assign gain_sel[1] = r_right_gain;

    // Each wheel product is built from a low unsigned and a high signed partial product.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            lo_prod[k] = $signed({1'b0, gain_sel[k]}) * $signed({1'b0, r_wheel[k][LO_W-1:0]});
            hi_prod[k] = $signed({1'b0, gain_sel[k]}) * $signed(r_wheel[k][WHEEL_W-1:LO_W]);
            // Shift rounds down; add one back for negative products with a remainder.
            q_c[k]     = Q_W'(r_acc[k] >>> CODE_SHIFT)
                         + Q_W'(r_acc[k][ACC_W-1] && (|r_acc[k][CODE_SHIFT-1:0]));
        end
    end

    assign right_sat = f_sat_q(r_q[1]);
    assign left_sat  = f_sat_q(r_q[0]);
    assign left_code = (left_sat == CODE_MIN) ? CODE_MAX : -left_sat;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        n_accel_step  = r_accel_step;
        n_accel_limit = r_accel_limit;
        n_decel_step  = r_decel_step;
        n_decel_limit = r_decel_limit;
        n_speed_tol   = r_speed_tol;
        n_speed_limit = r_speed_limit;
        n_left_gain   = r_left_gain;
        n_right_gain  = r_right_gain;
        n_accel       = r_accel;
        n_vel         = r_vel;
        n_req         = r_req;
        n_far         = r_far;
        n_up          = r_up;
        n_v           = r_v;
        n_turn        = r_turn;
        n_wheel       = r_wheel;
        n_cnt         = r_cnt;
        n_prod        = r_prod;
        n_acc         = r_acc;
        n_q           = r_q;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_kind    = r_out_kind;
        n_out_left    = r_out_left;
        n_out_right   = r_out_right;
        o_pop         = 1'b0;

        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ACCEL_STEP:  n_accel_step  = i_cfg_wdata[CFG_W-1:0];
                CFG_ACCEL_LIMIT: n_accel_limit = i_cfg_wdata[CFG_W-1:0];
                CFG_DECEL_STEP:  n_decel_step  = i_cfg_wdata[CFG_W-1:0];
                CFG_DECEL_LIMIT: n_decel_limit = i_cfg_wdata[CFG_W-1:0];
                CFG_SPEED_TOL:   n_speed_tol   = i_cfg_wdata[CFG_W-1:0];
                CFG_SPEED_LIMIT: n_speed_limit = i_cfg_wdata[CFG_W-1:0];
                CFG_LEFT_GAIN:   n_left_gain   = i_cfg_wdata[GAIN_W-1:0];
                CFG_RIGHT_GAIN:  n_right_gain  = i_cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_req = i_head;
                    n_far = head_abs > {2'b00, r_speed_tol};
                    n_up  = head_diff > 0;
                    case (i_head.op)
                        OP_DISABLE: begin
                            n_accel = '0;
                            n_vel   = '0;
                            n_state = ST_SAT;
                        end
                        OP_RAMP:  n_state = ST_ACC;
                        OP_PASS:  n_state = ST_CLAMP;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ACC: begin
                if (r_far) begin
                    n_accel = acc_new;
                end
                n_state = ST_VEL;
            end
            ST_VEL: begin
                if (r_far) begin
                    n_vel = vel_sat;
                end
                n_state = ST_SNAP;
            end
            ST_SNAP: begin
                if (snap_abs <= 17'(snap_tol)) begin
                    n_vel   = r_req.target_velocity;
                    n_accel = '0;
                end
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                n_v     = v_clamped;
                n_turn  = turn_c;
                n_state = ST_MIX;
            end
            ST_MIX: begin
                n_wheel[0] = vs_c - turn_ext;
                n_wheel[1] = vs_c + turn_ext;
                n_cnt      = '0;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                // Multiply into the product register, accumulate the registered product in the next cycle.
                for (int k = 0; k < 2; k++) begin
                    case (r_cnt)
                        2'd0: n_prod[k] = PROD_W'(lo_prod[k]);
                        2'd1: begin
                            n_prod[k] = PROD_W'(hi_prod[k]);
                            n_acc[k]  = ACC_W'(r_prod[k]);
                        end
                        default: n_acc[k] = r_acc[k] + (ACC_W'(r_prod[k]) <<< LO_W);
                    endcase
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 2'd2) begin
                    n_state = ST_CODE;
                end
            end
            ST_CODE: begin
                n_q     = q_c;
                n_state = ST_SAT;
            end
            ST_SAT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_req.op == OP_DISABLE) begin
                        n_out_kind  = KIND_DISABLE;
                        n_out_left  = '0;
                        n_out_right = '0;
                    end else begin
                        n_out_kind  = KIND_WHEEL;
                        n_out_left  = left_code;
                        n_out_right = right_sat;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_accel_step  <= RST_ACCEL_STEP;
            r_accel_limit <= RST_ACCEL_LIMIT;
            r_decel_step  <= RST_DECEL_STEP;
            r_decel_limit <= RST_DECEL_LIMIT;
            r_speed_tol   <= RST_SPEED_TOL;
            r_speed_limit <= RST_SPEED_LIMIT;
            r_left_gain   <= RST_LEFT_GAIN;
            r_right_gain  <= RST_RIGHT_GAIN;
            r_accel       <= '0;
            r_vel         <= '0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_accel_step  <= n_accel_step;
            r_accel_limit <= n_accel_limit;
            r_decel_step  <= n_decel_step;
            r_decel_limit <= n_decel_limit;
            r_speed_tol   <= n_speed_tol;
            r_speed_limit <= n_speed_limit;
            r_left_gain   <= n_left_gain;
            r_right_gain  <= n_right_gain;
            r_accel       <= n_accel;
            r_vel         <= n_vel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_far       <= n_far;
        r_up        <= n_up;
        r_v         <= n_v;
        r_turn      <= n_turn;
        r_wheel     <= n_wheel;
        r_cnt       <= n_cnt;
        r_prod      <= n_prod;
        r_acc       <= n_acc;
        r_q         <= n_q;
        r_out_kind  <= n_out_kind;
        r_out_left  <= n_out_left;
        r_out_right <= n_out_right;
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_kind      = r_out_kind;
    assign o_left_speed_code  = r_out_left;
    assign o_right_speed_code = r_out_right;

endmodule
